// ===== rtl/lfo_pkg.sv =====
// shared constants, codes and the sine table entry function of the oscillator
package lfo_pkg;

	// request operation codes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_TRIGGER = 1'b1;

	// waveform selector codes, the other codes give silence
	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_SQUARE   = 3'd1;
	localparam logic [2:0] WAVE_SAW_UP   = 3'd2;
	localparam logic [2:0] WAVE_SAW_DOWN = 3'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd1;

	// payload widths
	localparam int WAVE_W   = 3;
	localparam int FRAC32_W = 32;
	localparam int SAMPLE_W = 16;
	localparam int TAB_W    = 15;

	// pi/2 in q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;

	// sin(x) for x in q30 by a truncating taylor series, scaled to q15 with rounding
	function automatic logic [TAB_W-1:0] sine_entry(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] val;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + signed'(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - signed'(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum = sum + signed'(term);
		if (sum < 0) begin
			sum = '0;
		end
		val = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return val[TAB_W-1:0];
	endfunction

endpackage

// ===== rtl/lfo_ifs.sv =====
// handshake channel interfaces of the oscillator: request, result and register write
interface lfo_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] start_phase;

	modport source(output valid, output operation, output start_phase, input ready);
	modport sink(input valid, input operation, input start_phase, output ready);
endinterface

interface lfo_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface lfo_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/lfo_waveform_generator.sv =====
// top level of the phase accumulator low frequency oscillator
//
// low frequency oscillator: a phase accumulator holds the phase as an unsigned
// fraction of one cycle and wraps modulo one. a tick word on req returns one q1.15
// sample on rsp for the current phase and then adds phase_step; a trigger word
// loads start_phase and returns nothing. wave_select picks sine (quarter-wave
// table with linear interpolation), square, rising saw or falling saw, any other
// code gives zero. register writes on cfg are taken at once and must only happen
// while no word is in flight. the block accepts one word every cycle; a tick's
// sample is registered in stages 1 to 4 and then the result register. that rate
// comes from the phase memory: its registered read is forwarded from the
// write-back of the word ahead, so back-to-back words see the updated phase
// without an interlock. the stages between req and rsp each hold a word, so req
// stays ready while a sample waits on rsp as long as a stage is free
module lfo_waveform_generator #(
	parameter int PHASE_BITS       = 32,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	lfo_req_if.sink       req,
	lfo_rsp_if.source     rsp,
	lfo_cfg_if.sink       cfg
);

	// alignment between 32-bit fractions and the accumulator width
	localparam int UP = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
	localparam int DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
	localparam int WW = 32 + UP;
	// table addressing
	localparam int DW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW = 31 + DW;
	localparam int IW = $clog2(SINE_TABLE_DEPTH + 2);
	localparam int TW = lfo_pkg::TAB_W;
	localparam int SW = lfo_pkg::SAMPLE_W;

	// configuration registers
	logic [lfo_pkg::WAVE_W-1:0]   wave_q;
	logic [lfo_pkg::FRAC32_W-1:0] step_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic load_s2, load_s3, load_s4, load_out;
	logic accept, wr_en;

	// stage 1: word and phase read back from the memory
	logic                  op_s1;
	logic [31:0]           start_s1;
	logic [PHASE_BITS-1:0] phase_s1;
	logic [PHASE_BITS-1:0] phase_nxt;
	logic [PHASE_BITS-1:0] step_al;
	logic [PHASE_BITS-1:0] start_al;
	logic [WW-1:0]         step_w, start_w, p32_w;
	logic [31:0]           p32;
	logic [30:0]           r_off;
	logic [PW-1:0]         pos;
	logic [16:0]           fall_w;
	logic signed [SW-1:0]  alt;

	// stage 2: table address
	logic [IW-1:0]        idx_s2;
	logic [29:0]          frac_s2;
	logic                 neg_s2, sine_s2;
	logic signed [SW-1:0] alt_s2;

	// stage 3: table entries
	logic [TW-1:0]        lo_s3, hi_s3;
	logic [29:0]          frac_s3;
	logic                 neg_s3, sine_s3;
	logic signed [SW-1:0] alt_s3;
	logic [TW-1:0]        diff;
	logic [TW+29:0]       prod;

	// stage 4: interpolation product
	logic [TW-1:0]        lo_s4, add_s4;
	logic                 neg_s4, sine_s4;
	logic signed [SW-1:0] alt_s4;
	logic [SW-1:0]        mag;
	logic signed [SW-1:0] sine_val;

	logic signed [SW-1:0] sample_q;

	// register writes, indexes past the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= lfo_pkg::WAVE_SINE;
			step_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lfo_pkg::CFG_WAVE_SELECT: wave_q <= cfg.data[lfo_pkg::WAVE_W-1:0];
				lfo_pkg::CFG_PHASE_STEP:  step_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// each stage loads when empty or when the stage after it moves on
	assign load_out  = !out_v_q || rsp.ready;
	assign load_s4   = !v_s4 || load_out;
	assign load_s3   = !v_s3 || load_s4;
	assign load_s2   = !v_s2 || load_s3;
	assign req.ready = !v_s1 || load_s2;
	assign accept    = req.valid && req.ready;
	// the phase is written back as the word leaves stage 1
	assign wr_en     = v_s1 && load_s2;

	lfo_phase_store #(
		.PHASE_BITS(PHASE_BITS)
	) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.wr_en  (wr_en),
		.wr_data(phase_nxt),
		.rd_data(phase_s1)
	);

	// 32-bit fractions to accumulator width and back
	assign step_w   = (WW'(step_q) << UP) >> DN;
	assign start_w  = (WW'(start_s1) << UP) >> DN;
	assign step_al  = step_w[PHASE_BITS-1:0];
	assign start_al = start_w[PHASE_BITS-1:0];
	assign p32_w    = (WW'(phase_s1) << DN) >> UP;
	assign p32      = p32_w[31:0];

	assign phase_nxt = (op_s1 == lfo_pkg::OP_TRIGGER) ? start_al : phase_s1 + step_al;

	// quarter-wave offset, mirrored in the second and fourth quarters
	always_comb begin
		r_off = {1'b0, p32[29:0]};
		if (p32[30]) begin
			r_off = 31'h4000_0000 - r_off;
		end
	end

	assign pos = PW'(r_off) * PW'(SINE_TABLE_DEPTH);

	// falling saw, +1 at phase zero saturates
	assign fall_w = 17'h0_8000 - {1'b0, p32[31:16]};

	always_comb begin
		case (wave_q)
			lfo_pkg::WAVE_SQUARE:   alt = p32[31] ? lfo_pkg::Q15_MIN : lfo_pkg::Q15_MAX;
			lfo_pkg::WAVE_SAW_UP:   alt = signed'({~p32[31], p32[30:16]});
			lfo_pkg::WAVE_SAW_DOWN: alt = (p32[31:16] == 16'd0) ? lfo_pkg::Q15_MAX
			                              : signed'(fall_w[SW-1:0]);
			default:                alt = '0;
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			// only ticks go on past the phase update
			if (load_s2) begin
				v_s2 <= v_s1 && (op_s1 == lfo_pkg::OP_TICK);
			end
			if (load_s3) begin
				v_s3 <= v_s2;
			end
			if (load_s4) begin
				v_s4 <= v_s3;
			end
			if (load_out) begin
				out_v_q <= v_s4;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= req.operation;
			start_s1 <= req.start_phase;
		end
		if (load_s2) begin
			idx_s2  <= IW'(pos >> 30);
			frac_s2 <= pos[29:0];
			neg_s2  <= p32[31];
			sine_s2 <= (wave_q == lfo_pkg::WAVE_SINE);
			alt_s2  <= alt;
		end
		if (load_s3) begin
			frac_s3 <= frac_s2;
			neg_s3  <= neg_s2;
			sine_s3 <= sine_s2;
			alt_s3  <= alt_s2;
		end
		if (load_s4) begin
			lo_s4   <= lo_s3;
			add_s4  <= prod[TW+29:30];
			neg_s4  <= neg_s3;
			sine_s4 <= sine_s3;
			alt_s4  <= alt_s3;
		end
		if (load_out) begin
			sample_q <= sine_s4 ? sine_val : alt_s4;
		end
	end

	lfo_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk(clk),
		.en (load_s3),
		.idx(idx_s2),
		.lo (lo_s3),
		.hi (hi_s3)
	);

	// linear interpolation between neighboring entries
	assign diff = ((frac_s3 != 30'd0) && (hi_s3 > lo_s3)) ? hi_s3 - lo_s3 : '0;
	assign prod = (TW + 30)'(diff) * (TW + 30)'(frac_s3);

	// second half of the cycle negates
	assign mag      = {1'b0, lo_s4} + {1'b0, add_s4};
	assign sine_val = neg_s4 ? -signed'(mag) : signed'(mag);

	assign rsp.valid  = out_v_q;
	assign rsp.sample = sample_q;

endmodule

// ===== rtl/lfo_phase_store.sv =====
// phase memory: one entry, registered read with write-first forwarding
module lfo_phase_store #(
	parameter int PHASE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic                  wr_en,
	input  logic [PHASE_BITS-1:0] wr_data,
	output logic [PHASE_BITS-1:0] rd_data
);

	logic [PHASE_BITS-1:0] mem [0:0];
	logic                  written_q;
	logic [PHASE_BITS-1:0] rd_q;

	// entry reads as zero until the first write after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= 1'b0;
		end else if (wr_en) begin
			written_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[0] <= wr_data;
		end
	end

	// a read in the same cycle as a write sees the new phase
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en) begin
				rd_q <= wr_data;
			end else if (written_q) begin
				rd_q <= mem[0];
			end else begin
				rd_q <= '0;
			end
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/lfo_sine_rom.sv =====
// quarter-wave sine rom with two registered read ports for interpolation
module lfo_sine_rom #(
	parameter int DEPTH = 256,
	localparam int IW = $clog2(DEPTH + 2)
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [IW-1:0]                idx,
	output logic [lfo_pkg::TAB_W-1:0]    lo,
	output logic [lfo_pkg::TAB_W-1:0]    hi
);

	logic [lfo_pkg::TAB_W-1:0] rom [0:DEPTH+1];
	logic [lfo_pkg::TAB_W-1:0] lo_s3;
	logic [lfo_pkg::TAB_W-1:0] hi_s3;
	logic [IW-1:0]             idx_nxt;

	for (genvar g = 0; g <= DEPTH; g++) begin : g_tab
		localparam logic [63:0] X = (lfo_pkg::HALF_PI_Q30 * 64'(g)) / DEPTH;
		assign rom[g] = lfo_pkg::sine_entry(X);
	end

	// guard entry past the quarter end repeats the last value
	assign rom[DEPTH+1] = rom[DEPTH];

	assign idx_nxt = idx + IW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= rom[idx];
			hi_s3 <= rom[idx_nxt];
		end
	end

	assign lo = lo_s3;
	assign hi = hi_s3;

endmodule

// ===== rtl/lfo_checker.sv =====
// port-level checks of the oscillator and their binding to the top level
module lfo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [15:0] rsp_sample,
	input logic               cfg_ready
);

	// a waiting sample holds until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
		else $error("sample changed or dropped while stalled");

	// with the result side empty the whole pipeline can move, so req is ready
	a_req_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req not ready with empty result register");

	// register writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register port stalled");

	// nothing is shown right after reset is released
	a_rsp_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !rsp_valid)
		else $error("sample valid out of reset");

endmodule

bind lfo_waveform_generator lfo_checker u_lfo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_sample(rsp.sample),
	.cfg_ready (cfg.ready)
);

// ===== tb/lfo_waveform_generator_test.sv =====
// self-checking testbench of the phase accumulator low frequency oscillator
`timescale 1ns / 1ps

module lfo_waveform_generator_test;

	// block configuration under test, the predictor works at 32 phase bits
	localparam int TAB_DEPTH = 256;

	// register indexes past the end of the list, writes there are dropped
	localparam logic [lfo_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [lfo_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	// waveform codes that give silence
	localparam logic [lfo_pkg::WAVE_W-1:0] WAVE_MUTE_LO = 3'd4;
	localparam logic [lfo_pkg::WAVE_W-1:0] WAVE_MUTE_HI = 3'd7;

	// leave room for a trailing trigger to leave the pipeline
	localparam int DRAIN_CYCLES = 8;
	// long receiver hold-off, well past what the pipeline can buffer
	localparam int HOLD_CYCLES = 300;
	// cycles with no word moving on any channel before the run is called hung
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	lfo_req_if req_if();
	lfo_rsp_if rsp_if();
	lfo_cfg_if cfg_if();

	lfo_waveform_generator #(
		.PHASE_BITS(32),
		.SINE_TABLE_DEPTH(TAB_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: own copy of the registers and the phase
	logic [lfo_pkg::WAVE_W-1:0]   osc_wave;
	logic [lfo_pkg::FRAC32_W-1:0] osc_step;
	logic [lfo_pkg::FRAC32_W-1:0] osc_phase;
	longint unsigned              quarter_sine[0:TAB_DEPTH+1];

	// samples still owed by the block, oldest first
	logic signed [lfo_pkg::SAMPLE_W-1:0] pending_samples[$];

	int  mismatches;
	int  quiet_cycles;
	int  hold_left;
	bit  hold_off_req;
	bit  send_gaps;
	bit  rsp_gaps;

	// quarter-wave table: truncating taylor series of sin in q30, then q15 rounded half up
	function automatic void fill_quarter_sine();
		longint unsigned x, x2, term, val;
		longint acc;
		for (int i = 0; i <= TAB_DEPTH; i++) begin
			x = (lfo_pkg::HALF_PI_Q30 * longint'(i)) / TAB_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			acc = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			val = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
			if (val > 32767) begin
				val = 32767;
			end
			quarter_sine[i] = val;
		end
		// guard entry so the mirror at the quarter end reads a neighbor
		quarter_sine[TAB_DEPTH + 1] = quarter_sine[TAB_DEPTH];
	endfunction

	// interpolated sine; odd quadrants mirror the offset, the upper half negates
	function automatic logic signed [lfo_pkg::SAMPLE_W-1:0] sine_at(input logic [31:0] p32);
		longint unsigned ofs, pos, idx, frac, lo, hi, v;
		logic signed [lfo_pkg::SAMPLE_W-1:0] mag;
		ofs = p32[29:0];
		if (p32[30]) begin
			ofs = (64'd1 << 30) - ofs;
		end
		pos = ofs * TAB_DEPTH;
		idx = pos >> 30;
		frac = pos & ((64'd1 << 30) - 1);
		if (idx > TAB_DEPTH) begin
			idx = TAB_DEPTH;
		end
		lo = quarter_sine[idx];
		hi = quarter_sine[idx + 1];
		v = lo;
		if (frac != 0 && hi > lo) begin
			v = lo + (((hi - lo) * frac) >> 30);
		end
		mag = v[lfo_pkg::SAMPLE_W-1:0];
		return p32[31] ? -mag : mag;
	endfunction

	// sample for the current phase, then advance the phase by the step
	function automatic logic signed [lfo_pkg::SAMPLE_W-1:0] tick_sample();
		int v;
		logic signed [lfo_pkg::SAMPLE_W-1:0] s;
		case (osc_wave)
			lfo_pkg::WAVE_SINE: s = sine_at(osc_phase);
			lfo_pkg::WAVE_SQUARE: s = osc_phase[31] ? lfo_pkg::Q15_MIN : lfo_pkg::Q15_MAX;
			lfo_pkg::WAVE_SAW_UP: begin
				v = int'(osc_phase[31:16]) - 32768;
				s = v[lfo_pkg::SAMPLE_W-1:0];
			end
			lfo_pkg::WAVE_SAW_DOWN: begin
				// +1 at phase zero saturates
				v = 32768 - int'(osc_phase[31:16]);
				if (v > 32767) begin
					v = 32767;
				end
				s = v[lfo_pkg::SAMPLE_W-1:0];
			end
			default: s = '0;
		endcase
		osc_phase = osc_phase + osc_step;
		return s;
	endfunction

	// one word on req; gaps before it when enabled, predicted at acceptance
	task automatic send_word(input logic op, input logic [31:0] phase);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.operation <= op;
		req_if.start_phase <= phase;
		do @(posedge clk); while (!req_if.ready);
		if (op == lfo_pkg::OP_TRIGGER) begin
			osc_phase = phase;
		end else begin
			pending_samples.push_back(tick_sample());
		end
	endtask

	task automatic trigger_then_tick(input logic [31:0] phase);
		send_word(lfo_pkg::OP_TRIGGER, phase);
		send_word(lfo_pkg::OP_TICK, $urandom);
	endtask

	// stop offering, wait for every owed sample, then let a trailing trigger drain
	task automatic drain();
		req_if.valid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only with nothing in flight
	task automatic write_reg(input logic [lfo_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
		drain();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		// bits above the register width are dropped, spare indexes change nothing
		if (idx == lfo_pkg::CFG_WAVE_SELECT) begin
			osc_wave = data[lfo_pkg::WAVE_W-1:0];
		end else if (idx == lfo_pkg::CFG_PHASE_STEP) begin
			osc_step = data;
		end
	endtask

	// random phase, now and then one of the quadrant edges
	function automatic logic [31:0] pick_phase();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h4000_0000;
			3: return 32'h8000_0000;
			4: return 32'hC000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	// mostly ticks, some triggers with random or edge phases
	task automatic send_random_words(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 6) == 0) begin
				send_word(lfo_pkg::OP_TRIGGER, pick_phase());
			end else begin
				send_word(lfo_pkg::OP_TICK, $urandom);
			end
		end
	endtask

	// reset values: sine at phase zero with zero step, spare indexes ignored
	task automatic test_reset_state();
		send_word(lfo_pkg::OP_TICK, $urandom);
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		send_word(lfo_pkg::OP_TICK, $urandom);
	endtask

	// each waveform at its edges, wrap with the largest step, silent codes
	task automatic test_waveforms();
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'($urandom), lfo_pkg::WAVE_SINE});
		trigger_then_tick(32'h0000_0000);
		trigger_then_tick(32'h4000_0000);  // quarter end, last table entry alone
		trigger_then_tick(32'h8000_0000);
		trigger_then_tick(32'hC000_0000);
		trigger_then_tick(32'hFFFF_FFFF);
		trigger_then_tick(32'h1234_5678);  // interpolated between entries
		// upper data bits set, only the low three count
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'h1FFF_FFFF, lfo_pkg::WAVE_SQUARE});
		trigger_then_tick(32'h7FFF_FFFF);
		trigger_then_tick(32'h8000_0000);
		write_reg(lfo_pkg::CFG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, lfo_pkg::WAVE_SAW_UP});
		send_word(lfo_pkg::OP_TRIGGER, 32'h0000_0000);
		send_word(lfo_pkg::OP_TICK, $urandom);
		send_word(lfo_pkg::OP_TICK, $urandom);  // wrapped back to just under one
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, lfo_pkg::WAVE_SAW_DOWN});
		send_word(lfo_pkg::OP_TRIGGER, 32'h0000_0000);
		send_word(lfo_pkg::OP_TICK, $urandom);  // saturates to +1
		send_word(lfo_pkg::OP_TICK, $urandom);
		// silent code still advances the phase, the saw shows where it went
		write_reg(lfo_pkg::CFG_PHASE_STEP, 32'h2000_0000);
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, WAVE_MUTE_HI});
		send_word(lfo_pkg::OP_TICK, $urandom);
		send_word(lfo_pkg::OP_TICK, $urandom);
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, WAVE_MUTE_LO});
		send_word(lfo_pkg::OP_TICK, $urandom);
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, lfo_pkg::WAVE_SAW_UP});
		send_word(lfo_pkg::OP_TICK, $urandom);
	endtask

	// random settings, each followed by a batch of random words
	task automatic test_random_settings();
		logic [31:0] wsel;
		for (int ph = 0; ph < 8; ph++) begin
			wsel = $urandom;
			if ($urandom_range(0, 3) != 0) begin
				wsel[lfo_pkg::WAVE_W-1:0] = lfo_pkg::WAVE_W'($urandom_range(
					lfo_pkg::WAVE_SINE, lfo_pkg::WAVE_SAW_DOWN));
			end
			write_reg(lfo_pkg::CFG_WAVE_SELECT, wsel);
			write_reg(lfo_pkg::CFG_PHASE_STEP, pick_step());
			if ($urandom_range(0, 3) == 0) begin
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
			end
			// some batches without any gaps on one side
			send_gaps = (ph % 3) != 2;
			rsp_gaps = (ph % 4) != 3;
			send_random_words(58);
		end
		send_gaps = 1'b1;
		rsp_gaps = 1'b1;
	endtask

	// receiver holds off while ticks keep coming, so the input stalls
	task automatic test_output_stall();
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, lfo_pkg::WAVE_SINE});
		write_reg(lfo_pkg::CFG_PHASE_STEP, $urandom);
		send_gaps = 1'b0;
		hold_off_req <= 1'b1;
		for (int i = 0; i < 40; i++) begin
			send_word(lfo_pkg::OP_TICK, $urandom);
		end
		// sender pauses until everything owed has come
		drain();
		send_gaps = 1'b1;
	endtask

	// closing stretch, back to back on both sides
	task automatic test_full_rate();
		write_reg(lfo_pkg::CFG_WAVE_SELECT, {29'd0, lfo_pkg::WAVE_SAW_DOWN});
		write_reg(lfo_pkg::CFG_PHASE_STEP, pick_step());
		send_gaps = 1'b0;
		rsp_gaps = 1'b0;
		send_random_words(40);
	endtask

	// result checker and receiver ready: random gaps, plus the long hold-off
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_samples.size() == 0) begin
				$error("sample: expected none, actual %0d", rsp_if.sample);
				mismatches++;
			end else if (pending_samples[0] !== rsp_if.sample) begin
				$error("sample: expected %0d, actual %0d", pending_samples[0], rsp_if.sample);
				mismatches++;
				void'(pending_samples.pop_front());
			end else begin
				void'(pending_samples.pop_front());
			end
		end
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (hold_off_req) begin
			hold_off_req <= 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
			hold_left <= $urandom_range(0, 5);
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// watchdog: any word moving on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.operation = lfo_pkg::OP_TICK;
		req_if.start_phase = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = lfo_pkg::CFG_WAVE_SELECT;
		cfg_if.data = '0;
		rsp_if.ready = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		hold_left = 0;
		hold_off_req = 1'b0;
		send_gaps = 1'b1;
		rsp_gaps = 1'b1;
		// predictor starts from the reset state
		osc_wave = lfo_pkg::WAVE_SINE;
		osc_step = '0;
		osc_phase = '0;
		fill_quarter_sine();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_waveforms();
		test_random_settings();
		test_output_stall();
		test_full_rate();

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
